// ===== design/aivdm_sentence_encoder_macros.svh =====
// Assertion macros for the AIVDM sentence encoder checker.
// Depends on nothing; included by the checker file.
`ifndef AIVDM_SENTENCE_ENCODER_MACROS_SVH
`define AIVDM_SENTENCE_ENCODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AIVSE_IMPLIES(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define AIVSE_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== design/aivse_pkg.sv =====
// Shared types and constants of the AIVDM sentence encoder.
// No dependencies; used by every module of the block.
`default_nettype none

package aivse_pkg;

    localparam int MAX_PACKET_BYTES = 128;
    localparam int CHARS_PER_PART   = 59;
    localparam int FIFO_DEPTH       = 4;
    localparam int FIFO_AW          = $clog2(FIFO_DEPTH);

    // x / 6 as (x * RECIP6) >> 12, exact for x below 2048
    localparam int RECIP6 = 683;

    localparam logic [6:0] CH_BANG  = 7'h21;
    localparam logic [6:0] CH_COMMA = 7'h2c;
    localparam logic [6:0] CH_STAR  = 7'h2a;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_CR    = 7'h0d;
    localparam logic [6:0] CH_LF    = 7'h0a;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] total_bytes;
        logic       chan_sel;
        logic       first_of_packet;
    } t_in_item;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_of_run;
        logic       end_of_packet;
    } t_out_item;

    // One accepted byte, classified: the six-bit values it yields and the packet context.
    typedef struct packed {
        logic [5:0] v0;
        logic [5:0] v1;
        logic [5:0] v2;
        logic [1:0] n_vals;
        logic       fin;
        logic [2:0] pad;
        logic       start;
        logic [3:0] part_total;
        logic       multipart;
        logic       chan;
        logic [3:0] msg_id;
    } t_cmd;

endpackage

`default_nettype wire

// ===== design/aivse_front.sv =====
// Front end: accepts packet bytes, tracks bit framing and packet context.
// Depends on aivse_pkg.
`default_nettype none

module aivse_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire aivse_pkg::t_in_item i_data,
    input  wire                  i_full,
    output logic                 o_push,
    output aivse_pkg::t_cmd      o_cmd
);

    logic        r_in_pkt, n_in_pkt;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_seen, n_seen;
    logic [3:0]  r_res, n_res;
    logic [2:0]  r_rc, n_rc;
    logic        r_mp, n_mp;
    logic [3:0]  r_pt, n_pt;
    logic        r_ch, n_ch;
    logic [3:0]  r_msgid, n_msgid;

    logic        accept;
    logic [7:0]  tot;
    logic [10:0] nx;
    logic [20:0] prod;
    logic [8:0]  nchars;
    logic [7:0]  seen_c;
    logic [3:0]  res_c;
    logic [2:0]  rc_c;
    logic [11:0] acc;
    logic [8:0]  seen_inc;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        tot = i_data.total_bytes;
        if (tot == 8'd0) begin
            tot = 8'd1;
        end else if (9'(tot) > 9'(aivse_pkg::MAX_PACKET_BYTES)) begin
            tot = 8'(aivse_pkg::MAX_PACKET_BYTES);
        end
        nx     = {tot, 3'b000} + 11'd5;
        prod   = 21'(nx) * 21'(aivse_pkg::RECIP6);
        nchars = prod[20:12];
    end

    always_comb begin
        n_in_pkt = r_in_pkt;
        n_len    = r_len;
        n_seen   = r_seen;
        n_res    = r_res;
        n_rc     = r_rc;
        n_mp     = r_mp;
        n_pt     = r_pt;
        n_ch     = r_ch;
        n_msgid  = r_msgid;
        seen_c   = r_seen;
        res_c    = r_res;
        rc_c     = r_rc;
        o_cmd    = '0;
        o_push   = 1'b0;
        if (i_data.first_of_packet) begin
            n_in_pkt = 1'b1;
            n_len    = tot;
            seen_c   = 8'd0;
            res_c    = 4'd0;
            rc_c     = 3'd0;
            n_ch     = i_data.chan_sel;
            n_mp     = 32'(nchars) > aivse_pkg::CHARS_PER_PART + 1;
            n_pt     = 4'd1;
            if (n_mp) begin
                for (int k = 1; k < 6; k++) begin
                    if (32'(nchars) > k * aivse_pkg::CHARS_PER_PART) begin
                        n_pt = n_pt + 4'd1;
                    end
                end
            end
        end
        acc = {res_c, i_data.payload_byte};
        o_cmd.start      = i_data.first_of_packet;
        o_cmd.part_total = n_pt;
        o_cmd.multipart  = n_mp;
        o_cmd.chan       = n_ch;
        o_cmd.msg_id     = r_msgid;
        case (rc_c)
            3'd4: begin
                o_cmd.v0     = acc[11:6];
                o_cmd.v1     = acc[5:0];
                o_cmd.n_vals = 2'd2;
                n_rc         = 3'd0;
                n_res        = 4'd0;
            end
            3'd2: begin
                o_cmd.v0     = acc[9:4];
                o_cmd.n_vals = 2'd1;
                n_rc         = 3'd4;
                n_res        = acc[3:0];
            end
            default: begin
                o_cmd.v0     = acc[7:2];
                o_cmd.n_vals = 2'd1;
                n_rc         = 3'd2;
                n_res        = {2'b00, acc[1:0]};
            end
        endcase
        seen_inc = 9'(seen_c) + 9'd1;
        n_seen   = seen_inc[7:0];
        if (seen_inc >= 9'(n_len)) begin
            o_cmd.fin = 1'b1;
            if (n_rc == 3'd2) begin
                o_cmd.pad = 3'd4;
                if (o_cmd.n_vals == 2'd1) begin
                    o_cmd.v1 = {n_res[1:0], 4'b0000};
                end else begin
                    o_cmd.v2 = {n_res[1:0], 4'b0000};
                end
                o_cmd.n_vals = o_cmd.n_vals + 2'd1;
            end else if (n_rc == 3'd4) begin
                o_cmd.pad = 3'd2;
                o_cmd.v1  = {n_res[3:0], 2'b00};
                o_cmd.n_vals = o_cmd.n_vals + 2'd1;
            end
            n_in_pkt = 1'b0;
            n_res    = 4'd0;
            n_rc     = 3'd0;
            if (n_mp) begin
                n_msgid = (r_msgid >= 4'd9) ? 4'd0 : r_msgid + 4'd1;
            end
        end
        o_push = accept && (r_in_pkt || i_data.first_of_packet);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_pkt <= 1'b0;
            r_len    <= 8'd0;
            r_seen   <= 8'd0;
            r_res    <= 4'd0;
            r_rc     <= 3'd0;
            r_mp     <= 1'b0;
            r_pt     <= 4'd1;
            r_ch     <= 1'b0;
            r_msgid  <= 4'd0;
        end else if (o_push) begin
            r_in_pkt <= n_in_pkt;
            r_len    <= n_len;
            r_seen   <= n_seen;
            r_res    <= n_res;
            r_rc     <= n_rc;
            r_mp     <= n_mp;
            r_pt     <= n_pt;
            r_ch     <= n_ch;
            r_msgid  <= n_msgid;
        end
    end

endmodule

`default_nettype wire

// ===== design/aivse_fifo.sv =====
// Short command queue between front end and sentence sequencer.
// Depends on aivse_pkg.
`default_nettype none

module aivse_fifo (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire aivse_pkg::t_cmd i_cmd,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_nonempty,
    output aivse_pkg::t_cmd  o_cmd
);

    aivse_pkg::t_cmd r_mem [aivse_pkg::FIFO_DEPTH];
    logic [aivse_pkg::FIFO_AW-1:0] r_wp, r_rp;
    logic [aivse_pkg::FIFO_AW:0]   r_cnt;

    assign o_full     = r_cnt == (aivse_pkg::FIFO_AW+1)'(aivse_pkg::FIFO_DEPTH);
    assign o_nonempty = r_cnt != '0;
    assign o_cmd      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/aivse_back.sv =====
// Sentence sequencer: emits header, armored payload and trailer characters.
// Depends on aivse_pkg.
`default_nettype none

module aivse_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_nonempty,
    input  wire aivse_pkg::t_cmd i_cmd,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire                  i_stall,
    output aivse_pkg::t_out_item o_data
);

    typedef enum logic [2:0] {
        P_VAL = 3'b001,
        P_HDR = 3'b010,
        P_TRL = 3'b100
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [3:0] r_idx, n_idx;
    logic [1:0] r_vidx, n_vidx;
    logic       r_fin, n_fin;
    logic [5:0] r_cip, n_cip;
    logic [3:0] r_pn, n_pn;
    logic [7:0] r_ck, n_ck;
    logic       r_ov;
    aivse_pkg::t_out_item r_out;

    logic       emit_en;
    logic       first_slot;
    logic [5:0] cip_eff;
    logic [3:0] pn_eff;
    logic [5:0] val;
    logic [6:0] c;
    logic       chk;
    logic       done;
    logic       eop;
    logic       part_end;
    logic [3:0] hdr_last;
    logic       hdr_done;

    function automatic logic [6:0] hexc(input logic [3:0] n);
        hexc = (n < 4'd10) ? 7'h30 + 7'(n) : 7'h37 + 7'(n);
    endfunction

    function automatic logic [6:0] digit(input logic [3:0] n);
        digit = aivse_pkg::CH_ZERO + 7'(n);
    endfunction

    assign emit_en  = i_nonempty && (!r_ov || !i_stall);
    assign o_pop    = emit_en && done;
    assign o_valid  = r_ov;
    assign o_data   = r_out;
    assign hdr_last = i_cmd.multipart ? 4'd14 : 4'd13;
    // header just sent: the next slot is the payload character it announces
    assign hdr_done = (r_idx == hdr_last);

    always_comb begin
        first_slot = (r_phase == P_VAL) && (r_vidx == 2'd0) && i_cmd.start;
        cip_eff    = first_slot ? 6'd0 : r_cip;
        pn_eff     = first_slot ? 4'd1 : r_pn;
        case (r_vidx)
            2'd0:    val = i_cmd.v0;
            2'd1:    val = i_cmd.v1;
            default: val = i_cmd.v2;
        endcase
        part_end = i_cmd.multipart
                   && (7'(cip_eff) + 7'd1 >= 7'(aivse_pkg::CHARS_PER_PART))
                   && (pn_eff < i_cmd.part_total);
    end

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_vidx  = r_vidx;
        n_fin   = r_fin;
        n_cip   = r_cip;
        n_pn    = r_pn;
        n_ck    = r_ck;
        c       = aivse_pkg::CH_COMMA;
        chk     = 1'b0;
        done    = 1'b0;
        eop     = 1'b0;
        unique case (r_phase)
            P_VAL: begin
                n_pn = pn_eff;
                if ((cip_eff == 6'd0) && !hdr_done) begin
                    c       = aivse_pkg::CH_BANG;
                    n_ck    = 8'd0;
                    n_cip   = 6'd0;
                    n_phase = P_HDR;
                    n_idx   = 4'd1;
                end else begin
                    c     = (val < 6'd40) ? 7'(val) + 7'd48 : 7'(val) + 7'd56;
                    chk   = 1'b1;
                    n_cip = cip_eff + 6'd1;
                    n_idx = 4'd0;
                    n_vidx = r_vidx + 2'd1;
                    if (part_end) begin
                        n_phase = P_TRL;
                        n_idx   = 4'd0;
                        n_fin   = 1'b0;
                    end else if (r_vidx + 2'd1 == i_cmd.n_vals) begin
                        if (i_cmd.fin) begin
                            n_phase = P_TRL;
                            n_idx   = 4'd0;
                            n_fin   = 1'b1;
                        end else begin
                            done   = 1'b1;
                            n_vidx = 2'd0;
                        end
                    end
                end
            end
            P_HDR: begin
                chk = 1'b1;
                case (r_idx)
                    4'd1:    c = 7'h41;
                    4'd2:    c = 7'h49;
                    4'd3:    c = 7'h56;
                    4'd4:    c = 7'h44;
                    4'd5:    c = 7'h4d;
                    4'd7:    c = i_cmd.multipart ? digit(i_cmd.part_total) : 7'h31;
                    4'd9:    c = i_cmd.multipart ? digit(r_pn) : 7'h31;
                    4'd11:   c = i_cmd.multipart ? digit(i_cmd.msg_id) : aivse_pkg::CH_COMMA;
                    4'd12:   c = i_cmd.multipart ? aivse_pkg::CH_COMMA
                                                 : 7'h41 + 7'(i_cmd.chan);
                    4'd13:   c = i_cmd.multipart ? 7'h41 + 7'(i_cmd.chan)
                                                 : aivse_pkg::CH_COMMA;
                    default: c = aivse_pkg::CH_COMMA;
                endcase
                if (r_idx == hdr_last) begin
                    n_phase = P_VAL;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            P_TRL: begin
                n_idx = r_idx + 4'd1;
                case (r_idx)
                    4'd0: begin
                        c   = aivse_pkg::CH_COMMA;
                        chk = 1'b1;
                    end
                    4'd1: begin
                        c   = r_fin ? digit({1'b0, i_cmd.pad}) : aivse_pkg::CH_ZERO;
                        chk = 1'b1;
                    end
                    4'd2:    c = aivse_pkg::CH_STAR;
                    4'd3:    c = hexc(r_ck[7:4]);
                    4'd4:    c = hexc(r_ck[3:0]);
                    4'd5:    c = aivse_pkg::CH_CR;
                    default: begin
                        c = aivse_pkg::CH_LF;
                        n_phase = P_VAL;
                        if (r_fin) begin
                            done   = 1'b1;
                            eop    = 1'b1;
                            n_vidx = 2'd0;
                        end else begin
                            n_pn  = r_pn + 4'd1;
                            n_cip = 6'd0;
                            if (r_vidx == i_cmd.n_vals) begin
                                if (i_cmd.fin) begin
                                    n_phase = P_TRL;
                                    n_idx   = 4'd0;
                                    n_fin   = 1'b1;
                                end else begin
                                    done   = 1'b1;
                                    n_vidx = 2'd0;
                                end
                            end
                        end
                    end
                endcase
            end
        endcase
        if (chk) begin
            n_ck = r_ck ^ {1'b0, c};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_VAL;
            r_idx   <= 4'd0;
            r_vidx  <= 2'd0;
            r_fin   <= 1'b0;
            r_cip   <= 6'd0;
            r_pn    <= 4'd1;
            r_ck    <= 8'd0;
            r_ov    <= 1'b0;
        end else begin
            if (emit_en) begin
                r_phase <= n_phase;
                r_idx   <= n_idx;
                r_vidx  <= n_vidx;
                r_fin   <= n_fin;
                r_cip   <= n_cip;
                r_pn    <= n_pn;
                r_ck    <= n_ck;
                r_ov    <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_en) begin
            r_out.out_char      <= c;
            r_out.last_of_run   <= done;
            r_out.end_of_packet <= eop;
        end
    end

endmodule

`default_nettype wire

// ===== design/aivdm_sentence_encoder.sv =====
// AIVDM sentence encoder: top level tying front end, queue and sequencer.
// Depends on aivse_pkg, aivse_front, aivse_fifo, aivse_back.
//
// Usage:
// - Input channel (i_in_valid / o_in_stall / i_in_data) moves one packet byte per
//   transfer, tagged with packet length, channel and a first-byte flag.
// - Output channel (o_out_valid / i_out_stall / o_out_data) moves one ASCII
//   character per transfer; last_of_run marks the final character caused by a
//   byte, end_of_packet marks the closing line feed of a packet.
// - The front end takes a byte whenever the four-entry command queue has
//   room; stray bytes outside a packet are dropped there.
// - The sequencer emits one character per cycle while the queue holds a
//   command and the receiver does not stall; a byte causes one or two payload
//   characters, plus 14-15 header and 7 trailer characters at sentence edges.
//   Sustained rate is set by this one-character-per-cycle output port.
// - A byte passes the command queue, then the output register.
// - While the receiver stalls, the output register holds and the queue fills;
//   once full, o_in_stall rises.
// - Synchronous reset empties the queue and output register and closes any
//   open packet; message id restarts at zero.
`default_nettype none

module aivdm_sentence_encoder (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire aivse_pkg::t_in_item i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output aivse_pkg::t_out_item  o_out_data
);

    logic            full;
    logic            push;
    logic            pop;
    logic            nonempty;
    aivse_pkg::t_cmd cmd_in;
    aivse_pkg::t_cmd cmd_out;

    // Classify bytes and hand commands to the queue.
    aivse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd_in)
    );

    // Decouple byte intake from character output.
    aivse_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cmd      (cmd_in),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_cmd      (cmd_out)
    );

    // Walk header, payload and trailer; pop the command on its last character.
    aivse_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (nonempty),
        .i_cmd      (cmd_out),
        .o_pop      (pop),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_data     (o_out_data)
    );

endmodule

`default_nettype wire

// ===== design/aivse_checker.sv =====
// Port-level checker for the AIVDM sentence encoder, bound to the top level.
// Depends on aivse_pkg and aivdm_sentence_encoder_macros.svh.
`default_nettype none
`include "aivdm_sentence_encoder_macros.svh"

module aivse_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_out_valid,
    input wire                  i_out_stall,
    input wire aivse_pkg::t_out_item o_out_data
);

    logic out_held;
    logic eop_out;
    logic eop_ok;
    logic star_out;
    logic star_ok;

    assign out_held = o_out_valid && i_out_stall;
    assign eop_out  = o_out_valid && o_out_data.end_of_packet;
    assign eop_ok   = o_out_data.last_of_run && (o_out_data.out_char == aivse_pkg::CH_LF);
    assign star_out = o_out_valid && (o_out_data.out_char == aivse_pkg::CH_STAR);
    assign star_ok  = !o_out_data.last_of_run && !o_out_data.end_of_packet;

    `AIVSE_NEXT(a_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(o_out_data), "hold lost")
    `AIVSE_IMPLIES(a_eop_lf, i_clk, i_rst_n, eop_out, eop_ok, "end of packet not on final LF")
    `AIVSE_IMPLIES(a_star_not_last, i_clk, i_rst_n, star_out, star_ok, "run ended inside trailer")

endmodule

bind aivdm_sentence_encoder aivse_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
